// ----- rtl/mjdcal_pkg.sv -----
package mjdcal_pkg;

  // Number of register stages between the input and output ports.
  localparam int unsigned NumStages = 8;

  // Julian day offset plus the Fliegel-Van Flandern shift, folded into one addend.
  localparam logic [21:0] JdShift = 22'd2468570;

  localparam logic [24:0] Cycle400  = 25'd146097;
  localparam logic [28:0] Cycle4000 = 29'd1461001;
  localparam logic [18:0] Days4yr   = 19'd1461;
  localparam logic [16:0] MonthDiv  = 17'd2447;
  localparam logic [16:0] DayScale  = 17'd80;
  localparam logic [27:0] YearScale = 28'd4000;
  localparam logic [18:0] MonthBias = 19'd31;
  localparam logic [16:0] SecPerDay = 17'd86400;

  // Reciprocal estimates: floor(2^s / d). Each quotient estimate is at most
  // one below the true quotient, so a single compare and increment fixes it.
  localparam int unsigned ShC   = 24;
  localparam int unsigned ShY   = 28;
  localparam int unsigned ShM   = 17;
  localparam int unsigned Sh100 = 13;

  localparam logic [8:0]  MulC      = 9'(4 * ((2 ** ShC) / 146097));
  localparam logic [19:0] MulY      = 20'(4000 * ((2 ** ShY) / 1461001));
  localparam logic [12:0] MulM      = 13'(80 * ((2 ** ShM) / 2447));
  localparam logic [6:0]  Recip100  = 7'((2 ** Sh100) / 100);

  localparam logic [13:0] Hundred     = 14'd100;
  localparam logic [13:0] CenturyBias = 14'd4900;
  localparam logic [23:0] DaysPerYear = 24'd367;
  localparam logic [23:0] LeapNum     = 24'd7;
  // Constant part of the MJD of January first: 30 + 1 + 1721029 - 2400001.
  localparam logic [23:0] Jan1Bias    = 24'(31 + 1721029 - 2400001);

  localparam logic [3:0] MonthWrap = 4'd11;

  // Days elapsed before month index m in the March-based year: (2447 * m) / 80.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:  r = 9'd0;
      4'd1:  r = 9'd30;
      4'd2:  r = 9'd61;
      4'd3:  r = 9'd91;
      4'd4:  r = 9'd122;
      4'd5:  r = 9'd152;
      4'd6:  r = 9'd183;
      4'd7:  r = 9'd214;
      4'd8:  r = 9'd244;
      4'd9:  r = 9'd275;
      4'd10: r = 9'd305;
      4'd11: r = 9'd336;
      4'd12: r = 9'd367;
      4'd13: r = 9'd397;
      4'd14: r = 9'd428;
      4'd15: r = 9'd458;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/mjd_to_calendar_date.sv -----
// Channel   Valid     Stall     Payload
// input     valid_i   stall_o   day_number_i, day_fraction_i
// output    valid_o   stall_i   year_o, month_o, day_of_month_o, day_of_year_o,
//                               seconds_of_day_o
//
// One item is accepted per cycle while the output is not stalled. The date path
// has eight register stages, and the fraction multiplier runs alongside the
// first of them.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall on the output holds the last stage, and earlier stages keep filling
// any empty slots, so stall_o rises only once every stage holds an item.

module mjd_to_calendar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [19:0] day_number_i,
  input  logic [31:0] day_fraction_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [12:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [8:0]  day_of_year_o,
  output logic [32:0] seconds_of_day_o
);

  // Stage k loads when it is empty or when stage k+1 is loading too, so a
  // stall ripples back only as far as the pipeline is full.
  logic [mjdcal_pkg::NumStages:0]   en;
  logic [mjdcal_pkg::NumStages-1:0] valid_q;

  always_comb begin
    en[mjdcal_pkg::NumStages] = !stall_i;
    for (int k = mjdcal_pkg::NumStages - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];
  assign valid_o = valid_q[mjdcal_pkg::NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= valid_i;
      end
      for (int k = 1; k < mjdcal_pkg::NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 1: shifted Julian day and the estimate product for the 400-year
  // cycle; the day fraction is scaled to seconds in the same stage.
  logic [21:0] s1_j0_d, s1_j0_q;
  logic [30:0] s1_pc_d, s1_pc_q;
  logic [48:0] frac_prod;
  logic [19:0] s1_mjd_q;
  logic [32:0] s1_sec_q;

  always_comb begin
    s1_j0_d   = 22'(day_number_i) + mjdcal_pkg::JdShift;
    s1_pc_d   = 31'(s1_j0_d) * 31'(mjdcal_pkg::MulC);
    frac_prod = 49'(day_fraction_i) * 49'(mjdcal_pkg::SecPerDay);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_j0_q  <= s1_j0_d;
      s1_pc_q  <= s1_pc_d;
      s1_mjd_q <= day_number_i;
      s1_sec_q <= frac_prod[48:16];
    end
  end

  // Stage 2: correct the century-cycle quotient and take the day within it.
  // Both candidate subtrahends are formed from the one product.
  logic [6:0]  s2_c_est, s2_c_d, s2_c_q;
  logic [24:0] s2_cprod, s2_rem, s2_sub;
  logic        s2_hi;
  logic [15:0] s2_j1_d, s2_j1_q;
  logic [19:0] s2_mjd_q;
  logic [32:0] s2_sec_q;

  always_comb begin
    s2_c_est = 7'(s1_pc_q >> mjdcal_pkg::ShC);
    s2_cprod = 25'(s2_c_est) * mjdcal_pkg::Cycle400;
    s2_rem   = 25'({s1_j0_q, 2'b00}) - s2_cprod;
    s2_hi    = s2_rem >= mjdcal_pkg::Cycle400;
    s2_c_d   = s2_hi ? s2_c_est + 7'd1 : s2_c_est;
    s2_sub   = s2_hi ? s2_cprod + mjdcal_pkg::Cycle400 : s2_cprod;
    s2_j1_d  = 16'(25'(s1_j0_q) - ((s2_sub + 25'd3) >> 2));
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_c_q   <= s2_c_d;
      s2_j1_q  <= s2_j1_d;
      s2_mjd_q <= s1_mjd_q;
      s2_sec_q <= s1_sec_q;
    end
  end

  // Stage 3: estimate product for the year within the century.
  logic [36:0] s3_py_d, s3_py_q;
  logic [15:0] s3_j1_q;
  logic [6:0]  s3_c_q;
  logic [19:0] s3_mjd_q;
  logic [32:0] s3_sec_q;

  always_comb begin
    s3_py_d = 37'(17'(s2_j1_q) + 17'd1) * 37'(mjdcal_pkg::MulY);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_py_q  <= s3_py_d;
      s3_j1_q  <= s2_j1_q;
      s3_c_q   <= s2_c_q;
      s3_mjd_q <= s2_mjd_q;
      s3_sec_q <= s2_sec_q;
    end
  end

  // Stage 4: correct the year quotient and take the day within the year,
  // counted from the first of March.
  logic [7:0]  s4_y_est, s4_y_d, s4_y_q;
  logic [27:0] s4_x;
  logic [28:0] s4_yprod, s4_rem;
  logic        s4_hi;
  logic [18:0] s4_tlo, s4_t;
  logic [9:0]  s4_j2_d, s4_j2_q;
  logic [6:0]  s4_c_q;
  logic [19:0] s4_mjd_q;
  logic [32:0] s4_sec_q;

  always_comb begin
    s4_y_est = 8'(s3_py_q >> mjdcal_pkg::ShY);
    s4_x     = 28'(17'(s3_j1_q) + 17'd1) * mjdcal_pkg::YearScale;
    s4_yprod = 29'(s4_y_est) * mjdcal_pkg::Cycle4000;
    s4_rem   = 29'(s4_x) - s4_yprod;
    s4_hi    = s4_rem >= mjdcal_pkg::Cycle4000;
    s4_y_d   = s4_hi ? s4_y_est + 8'd1 : s4_y_est;
    s4_tlo   = 19'(s4_y_est) * mjdcal_pkg::Days4yr;
    s4_t     = s4_hi ? s4_tlo + mjdcal_pkg::Days4yr : s4_tlo;
    s4_j2_d  = 10'(19'(s3_j1_q) - (s4_t >> 2) + mjdcal_pkg::MonthBias);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_y_q   <= s4_y_d;
      s4_j2_q  <= s4_j2_d;
      s4_c_q   <= s3_c_q;
      s4_mjd_q <= s3_mjd_q;
      s4_sec_q <= s3_sec_q;
    end
  end

  // Stage 5: estimate product for the month index.
  logic [22:0] s5_pm_d, s5_pm_q;
  logic [9:0]  s5_j2_q;
  logic [7:0]  s5_y_q;
  logic [6:0]  s5_c_q;
  logic [19:0] s5_mjd_q;
  logic [32:0] s5_sec_q;

  always_comb begin
    s5_pm_d = 23'(s4_j2_q) * 23'(mjdcal_pkg::MulM);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_pm_q  <= s5_pm_d;
      s5_j2_q  <= s4_j2_q;
      s5_y_q   <= s4_y_q;
      s5_c_q   <= s4_c_q;
      s5_mjd_q <= s4_mjd_q;
      s5_sec_q <= s4_sec_q;
    end
  end

  // Stage 6: correct the month index, then day of month, calendar month and
  // year. January and February belong to the next calendar year.
  logic [3:0]  s6_m_est, s6_m;
  logic [16:0] s6_mprod, s6_rem;
  logic        s6_wrap;
  logic [3:0]  s6_mon_d, s6_mon_q;
  logic [4:0]  s6_day_d, s6_day_q;
  logic [12:0] s6_yr_d, s6_yr_q;
  logic [19:0] s6_mjd_q;
  logic [32:0] s6_sec_q;

  always_comb begin
    s6_m_est = 4'(s5_pm_q >> mjdcal_pkg::ShM);
    s6_mprod = 17'(s6_m_est) * mjdcal_pkg::MonthDiv;
    s6_rem   = 17'(s5_j2_q) * mjdcal_pkg::DayScale - s6_mprod;
    s6_m     = (s6_rem >= mjdcal_pkg::MonthDiv) ? s6_m_est + 4'd1 : s6_m_est;
    s6_day_d = 5'(s5_j2_q - 10'(mjdcal_pkg::month_start(s6_m)));
    s6_wrap  = s6_m >= mjdcal_pkg::MonthWrap;
    s6_mon_d = s6_wrap ? s6_m - 4'd10 : s6_m + 4'd2;
    s6_yr_d  = 13'(14'(s5_c_q) * mjdcal_pkg::Hundred - mjdcal_pkg::CenturyBias
                   + 14'(s5_y_q) + 14'(s6_wrap));
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_mon_q <= s6_mon_d;
      s6_day_q <= s6_day_d;
      s6_yr_q  <= s6_yr_d;
      s6_mjd_q <= s5_mjd_q;
      s6_sec_q <= s5_sec_q;
    end
  end

  // Stage 7: start on the MJD of January first of that year. The century
  // count needs (year - 1) / 100, estimated here and corrected next stage.
  logic [12:0] s7_yrm1_d, s7_yrm1_q;
  logic [19:0] s7_pcent_d, s7_pcent_q;
  logic [23:0] s7_base_d, s7_base_q;
  logic [12:0] s7_yr_q;
  logic [3:0]  s7_mon_q;
  logic [4:0]  s7_day_q;
  logic [19:0] s7_mjd_q;
  logic [32:0] s7_sec_q;

  always_comb begin
    s7_yrm1_d  = s6_yr_q - 13'd1;
    s7_pcent_d = 20'(s7_yrm1_d) * 20'(mjdcal_pkg::Recip100);
    s7_base_d  = 24'(s6_yr_q) * mjdcal_pkg::DaysPerYear
                 - ((24'(s6_yr_q) * mjdcal_pkg::LeapNum) >> 2)
                 + mjdcal_pkg::Jan1Bias;
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_yrm1_q  <= s7_yrm1_d;
      s7_pcent_q <= s7_pcent_d;
      s7_base_q  <= s7_base_d;
      s7_yr_q    <= s6_yr_q;
      s7_mon_q   <= s6_mon_q;
      s7_day_q   <= s6_day_q;
      s7_mjd_q   <= s6_mjd_q;
      s7_sec_q   <= s6_sec_q;
    end
  end

  // Stage 8: finish the century correction and form the day of year. Two's
  // complement wrap is harmless because only the low nine bits are kept.
  logic [6:0]  s8_q_est, s8_cent;
  logic [13:0] s8_rem;
  logic [23:0] s8_jan1;
  logic [8:0]  s8_doy_d;

  always_comb begin
    s8_q_est = 7'(s7_pcent_q >> mjdcal_pkg::Sh100);
    s8_rem   = 14'(s7_yrm1_q) - 14'(s8_q_est) * mjdcal_pkg::Hundred;
    s8_cent  = (s8_rem >= mjdcal_pkg::Hundred) ? s8_q_est + 7'd2 : s8_q_est + 7'd1;
    s8_jan1  = s7_base_q - ((24'(s8_cent) * 24'd3) >> 2);
    s8_doy_d = 9'(24'(s7_mjd_q) - s8_jan1 + 24'd1);
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      year_o           <= s7_yr_q;
      month_o          <= s7_mon_q;
      day_of_month_o   <= s7_day_q;
      day_of_year_o    <= s8_doy_d;
      seconds_of_day_o <= s7_sec_q;
    end
  end

endmodule

// ----- rtl/mjdcal_checker.sv -----
module mjdcal_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [12:0] year_o,
  input logic [3:0]  month_o,
  input logic [4:0]  day_of_month_o,
  input logic [8:0]  day_of_year_o,
  input logic [32:0] seconds_of_day_o
);

  // A result held back by the consumer stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(year_o) && $stable(month_o)
      && $stable(day_of_month_o) && $stable(day_of_year_o) && $stable(seconds_of_day_o))
    else $error("result changed while stalled");

  // The input is only held off when every stage is full and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without output back-pressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> month_o >= 4'd1 && month_o <= 4'd12
      && day_of_month_o >= 5'd1 && day_of_month_o <= 5'd31)
    else $error("month or day of month out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> year_o >= 13'd1858 && year_o <= 13'd4730
      && day_of_year_o >= 9'd1 && day_of_year_o <= 9'd366
      && seconds_of_day_o <= 33'd5662310399)
    else $error("year, day of year or seconds out of range");

endmodule

bind mjd_to_calendar_date mjdcal_checker u_mjdcal_checker (.*);
